>>> rtl/core/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

	// Request kinds
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_FLUSH  = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Fixed stream bytes
	localparam logic [7:0] HDR_MARK  = 8'h00;
	localparam logic [7:0] TRL_MARK  = 8'hff;
	localparam logic [7:0] TRL_FILL  = 8'h00;

	// Header and trailer are five bytes each
	localparam int unsigned FRAME_BYTES = 5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] next_address;
		logic [15:0] entry_point;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} rsp_t;

endpackage

>>> rtl/core/binary_record_framer_unit.sv
`timescale 1ns / 1ps
// A request that emits bytes first sets the sequencer state, then the registered output byte.
// One output byte per cycle while rsp_ready is not held low; a request emitting k bytes
// holds the input until its last byte is registered (record of n data bytes: k = n + 5;
// a trailer adds 5). Appends that do not fill the buffer do not hold the input.
// Buffer RAM (one write and one read per cycle, registered read) feeds the data phase.
// Reset (arst_n low) clears the start address, fill count and sequencer; RAM is not cleared.
module binary_record_framer_unit #(
	parameter int RECORD_BYTES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  brf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output brf_pkg::rsp_t rsp
);

	localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int CW = $clog2(RECORD_BYTES + 1);
	localparam int IW = (AW > 3) ? AW : 3;
	localparam int XW = IW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HDR  = 2'd1;
	localparam logic [1:0] ST_DATA = 2'd2;
	localparam logic [1:0] ST_TRL  = 2'd3;

	logic [1:0]    state_q;
	logic [IW-1:0] idx_q;
	logic          trl_q;
	logic [CW-1:0] count_q;
	logic [15:0]   record_start_q;
	logic [CW-1:0] len_q;
	logic [15:0]   emit_addr_q;
	logic [15:0]   entry_q;
	logic [7:0]    rd_data_q;
	logic          rsp_valid_q;
	brf_pkg::rsp_t rsp_q;

	logic [7:0] mem [RECORD_BYTES];

	logic          accept;
	logic          advance;
	logic          busy;
	logic          last_data;
	logic          last_frame;
	logic [CW-1:0] count_inc;
	logic [AW-1:0] rd_addr;
	logic [15:0]   len16;
	logic [7:0]    cur_byte;
	logic          cur_last;

	assign accept    = req_valid && req_ready;
	assign busy      = (state_q != ST_IDLE);
	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign count_inc = CW'(count_q + 1'b1);
	assign len16     = 16'(len_q);
	assign last_data = (XW'(idx_q) + XW'(1)) == XW'(len_q);
	assign last_frame = (idx_q == IW'(brf_pkg::FRAME_BYTES - 1));

	// Buffer read address: step ahead one entry whenever a data byte other than the last leaves
	always_comb begin
		rd_addr = '0;
		if (state_q == ST_DATA) begin
			if (advance && !last_data) begin
				rd_addr = AW'(idx_q + IW'(1));
			end else begin
				rd_addr = AW'(idx_q);
			end
		end
	end

	// Byte for the current sequencer position
	always_comb begin
		cur_byte = brf_pkg::HDR_MARK;
		cur_last = 1'b0;
		case (state_q)
			ST_HDR: begin
				case (idx_q)
					IW'(0): cur_byte = brf_pkg::HDR_MARK;
					IW'(1): cur_byte = len16[15:8];
					IW'(2): cur_byte = len16[7:0];
					IW'(3): cur_byte = emit_addr_q[15:8];
					default: cur_byte = emit_addr_q[7:0];
				endcase
			end
			ST_DATA: begin
				cur_byte = rd_data_q;
				cur_last = last_data && !trl_q;
			end
			ST_TRL: begin
				case (idx_q)
					IW'(0): cur_byte = brf_pkg::TRL_MARK;
					IW'(1): cur_byte = brf_pkg::TRL_FILL;
					IW'(2): cur_byte = brf_pkg::TRL_FILL;
					IW'(3): cur_byte = entry_q[15:8];
					default: cur_byte = entry_q[7:0];
				endcase
				cur_last = last_frame;
			end
			default: begin
				cur_byte = brf_pkg::HDR_MARK;
				cur_last = 1'b0;
			end
		endcase
	end

	// Buffer RAM: append writes at the fill count, registered read
	always_ff @(posedge clk) begin
		if (accept && req.kind == brf_pkg::KIND_APPEND) begin
			mem[count_q[AW-1:0]] <= req.data_byte;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Snapshot of the record being emitted
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_addr_q <= record_start_q;
			entry_q     <= req.entry_point;
			if (req.kind == brf_pkg::KIND_APPEND) begin
				len_q <= count_inc;
			end else begin
				len_q <= count_q;
			end
		end
		if (advance && busy) begin
			rsp_q.out_byte <= cur_byte;
			rsp_q.last     <= cur_last;
		end
	end

	// Request decode, fill count and byte sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			trl_q          <= 1'b0;
			count_q        <= '0;
			record_start_q <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= busy;
			end
			if (accept) begin
				idx_q <= '0;
				trl_q <= (req.kind == brf_pkg::KIND_FINISH);
				case (req.kind)
					brf_pkg::KIND_APPEND: begin
						if (count_inc == CW'(RECORD_BYTES)) begin
							count_q        <= '0;
							record_start_q <= req.next_address;
							state_q        <= ST_HDR;
						end else begin
							count_q <= count_inc;
						end
					end
					brf_pkg::KIND_FLUSH: begin
						count_q        <= '0;
						record_start_q <= req.next_address;
						if (count_q != '0) begin
							state_q <= ST_HDR;
						end
					end
					brf_pkg::KIND_FINISH: begin
						count_q        <= '0;
						record_start_q <= req.next_address;
						state_q        <= (count_q != '0) ? ST_HDR : ST_TRL;
					end
					default: begin
					end
				endcase
			end else if (busy && advance) begin
				case (state_q)
					ST_HDR: begin
						if (last_frame) begin
							state_q <= ST_DATA;
							idx_q   <= '0;
						end else begin
							idx_q <= IW'(idx_q + 1'b1);
						end
					end
					ST_DATA: begin
						if (last_data) begin
							state_q <= trl_q ? ST_TRL : ST_IDLE;
							idx_q   <= '0;
						end else begin
							idx_q <= IW'(idx_q + 1'b1);
						end
					end
					ST_TRL: begin
						if (last_frame) begin
							state_q <= ST_IDLE;
							idx_q   <= '0;
						end else begin
							idx_q <= IW'(idx_q + 1'b1);
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// A pending record never holds a full buffer
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(RECORD_BYTES))
		else $error("fill count reached record size");

	// Data phase only runs for a non-empty record and stays inside it
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (len_q != '0) && (XW'(idx_q) < XW'(len_q)))
		else $error("data phase outside record");

	// A finish request always starts emitting
	a_finish_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == brf_pkg::KIND_FINISH) |=>
		(state_q == ST_HDR || state_q == ST_TRL))
		else $error("finish request produced no output");

	// The final byte of a request returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && advance && cur_last) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after final byte");

endmodule
